[rtl/core/ils_pkg.sv]
// Package for the indexed list store: request kinds, status codes, controller
// states and the command/status bundles between controller and datapath.
// No dependencies.
package ils_pkg;

   localparam int VALUE_W = 32;
   localparam int POS_W   = 8;
   localparam int KIND_W  = 3;
   localparam int STAT_W  = 2;
   localparam int OCNT_W  = 7;

   localparam logic [KIND_W-1:0] KIND_READ       = 3'd0;
   localparam logic [KIND_W-1:0] KIND_INS_FRONT  = 3'd1;
   localparam logic [KIND_W-1:0] KIND_APPEND     = 3'd2;
   localparam logic [KIND_W-1:0] KIND_INS_AT     = 3'd3;
   localparam logic [KIND_W-1:0] KIND_DELETE     = 3'd4;

   localparam logic [STAT_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_READ_WAIT,
      ST_INS_CHECK,
      ST_INS_MOVE,
      ST_DEL_CHECK,
      ST_DEL_MOVE,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      OP_READ,
      OP_INSERT,
      OP_DELETE,
      OP_NONE
   } op_type;

   typedef enum logic [1:0] {
      RD_HERE,
      RD_PREV,
      RD_NEXT
   } rd_sel_type;

   typedef enum logic {
      WR_MOVED,
      WR_NEW
   } wr_sel_type;

   typedef struct packed {
      logic              ready;
      logic              rd_en;
      rd_sel_type        rd_sel;
      logic              wr_en;
      wr_sel_type        wr_sel;
      logic              idx_inc;
      logic              idx_dec;
      logic              cnt_inc;
      logic              cnt_dec;
      logic              note_status;
      logic [STAT_W-1:0] status_code;
      logic              note_read;
      logic              rsp_load;
   } ctrl_cmd_type;

   typedef struct packed {
      logic   req_valid;
      op_type op;
      logic   range_err;
      logic   full_err;
      logic   at_target;
      logic   at_last;
      logic   rsp_free;
   } ctrl_stat_type;

endpackage

[rtl/core/ils_if.sv]
// Valid/ready channel interfaces for the indexed list store request and response.
// Depends on ils_pkg.
interface ils_req_if;
   import ils_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [KIND_W-1:0]         kind;
   logic [POS_W-1:0]          position;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, kind, position, value, input ready);
   modport sink   (input valid, kind, position, value, output ready);
endinterface

interface ils_rsp_if;
   import ils_pkg::*;
   logic                      valid;
   logic                      ready;
   logic                      read_valid;
   logic signed [VALUE_W-1:0] read_value;
   logic [STAT_W-1:0]         status;
   logic [OCNT_W-1:0]         entry_count;

   modport source (output valid, read_valid, read_value, status, entry_count, input ready);
   modport sink   (input valid, read_valid, read_value, status, entry_count, output ready);
endinterface

[rtl/core/ils_datapath.sv]
// Datapath of the indexed list store: entry memory, count, walking index,
// request capture and response register. Depends on ils_pkg and ils_if.
module ils_datapath
   import ils_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  logic          clock,
   input  logic          reset,
   ils_req_if.sink       req,
   ils_rsp_if.source     rsp,
   input  ctrl_cmd_type  cmd,
   output ctrl_stat_type stat
);

   localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int EW    = (CNT_W > POS_W) ? CNT_W : POS_W;

   logic [VALUE_W-1:0] mem [CAPACITY];
   logic [VALUE_W-1:0] rd_data_ff;

   logic [CNT_W-1:0]   count_ff, count_in;
   logic [AW-1:0]      idx_ff, idx_in;
   logic [KIND_W-1:0]  kind_ff;
   logic [POS_W-1:0]   pos_ff;
   logic [VALUE_W-1:0] value_ff;

   logic [STAT_W-1:0]  res_status_ff, res_status_in;
   logic               res_valid_ff, res_valid_in;
   logic [VALUE_W-1:0] res_value_ff, res_value_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_read_valid_ff;
   logic [VALUE_W-1:0] rsp_read_value_ff;
   logic [STAT_W-1:0]  rsp_status_ff;
   logic [OCNT_W-1:0]  rsp_count_ff;

   logic               capture;
   logic [EW-1:0]      eff_pos;
   logic [AW-1:0]      rd_addr;
   logic [VALUE_W-1:0] wr_data;

   assign capture   = req.valid && cmd.ready;
   assign req.ready = cmd.ready;

   always_comb begin
      case (kind_ff)
         KIND_INS_FRONT: eff_pos = '0;
         KIND_APPEND:    eff_pos = EW'(count_ff);
         default:        eff_pos = EW'(pos_ff);
      endcase
   end

   always_comb begin
      stat.req_valid = req.valid;
      stat.rsp_free  = !rsp_valid_ff || rsp.ready;
      stat.at_target = (EW'(idx_ff) == eff_pos);
      stat.at_last   = ((CNT_W'(idx_ff) + CNT_W'(1)) == count_ff);
      stat.full_err  = (count_ff >= CNT_W'(CAPACITY));
      stat.range_err = 1'b0;
      stat.op        = OP_NONE;
      unique case (kind_ff) inside
         KIND_READ: begin
            stat.op        = OP_READ;
            stat.range_err = (eff_pos >= EW'(count_ff));
         end
         KIND_INS_FRONT, KIND_APPEND, KIND_INS_AT: begin
            stat.op        = OP_INSERT;
            stat.range_err = (eff_pos > EW'(count_ff));
         end
         KIND_DELETE: begin
            stat.op        = OP_DELETE;
            stat.range_err = (eff_pos >= EW'(count_ff));
         end
         default: stat.op = OP_NONE;
      endcase
   end

   always_comb begin
      unique case (cmd.rd_sel)
         RD_PREV: rd_addr = idx_ff - AW'(1);
         RD_NEXT: rd_addr = idx_ff + AW'(1);
         default: rd_addr = idx_ff;
      endcase
      wr_data = (cmd.wr_sel == WR_NEW) ? value_ff : rd_data_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[idx_ff] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.cnt_inc) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - CNT_W'(1);
      end

      idx_in = idx_ff;
      if (capture) begin
         if (req.kind == KIND_READ || req.kind == KIND_DELETE) begin
            idx_in = req.position[AW-1:0];
         end else begin
            idx_in = AW'(count_ff);
         end
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + AW'(1);
      end else if (cmd.idx_dec) begin
         idx_in = idx_ff - AW'(1);
      end

      res_status_in = res_status_ff;
      res_valid_in  = res_valid_ff;
      res_value_in  = res_value_ff;
      if (capture) begin
         res_status_in = STATUS_DONE;
         res_valid_in  = 1'b0;
         res_value_in  = '0;
      end else begin
         if (cmd.note_status) begin
            res_status_in = cmd.status_code;
         end
         if (cmd.note_read) begin
            res_valid_in = 1'b1;
            res_value_in = rd_data_ff;
         end
      end

      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      res_status_ff <= res_status_in;
      res_valid_ff  <= res_valid_in;
      res_value_ff  <= res_value_in;
      if (capture) begin
         kind_ff  <= req.kind;
         pos_ff   <= req.position;
         value_ff <= req.value;
      end
      if (cmd.rsp_load) begin
         rsp_read_valid_ff <= res_valid_ff;
         rsp_read_value_ff <= res_value_ff;
         rsp_status_ff     <= res_status_ff;
         rsp_count_ff      <= OCNT_W'(count_ff);
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.read_valid  = rsp_read_valid_ff;
   assign rsp.read_value  = rsp_read_value_ff;
   assign rsp.status      = rsp_status_ff;
   assign rsp.entry_count = rsp_count_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || rsp.ready))
      else $error("response overwritten before it was taken");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      (!cmd.cnt_inc && !cmd.cnt_dec) |=> $stable(count_ff))
      else $error("count changed without a command");

   a_no_grow_full: assert property (@(posedge clock) disable iff (reset)
      cmd.cnt_inc |-> (count_ff < CNT_W'(CAPACITY)))
      else $error("insert into a full store");

   a_no_shrink_empty: assert property (@(posedge clock) disable iff (reset)
      cmd.cnt_dec |-> (count_ff != '0))
      else $error("delete from an empty store");
`endif

endmodule

[rtl/core/ils_ctrl.sv]
// Controller of the indexed list store: sequences capture, range checks,
// entry moves and the response load. Depends on ils_pkg.
module ils_ctrl
   import ils_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  ctrl_stat_type stat,
   output ctrl_cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.ready = 1'b1;
            if (stat.req_valid) begin
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (stat.op == OP_NONE) begin
               state_in = ST_FINISH;
            end else if (stat.range_err) begin
               cmd.note_status = 1'b1;
               cmd.status_code = STATUS_RANGE;
               state_in        = ST_FINISH;
            end else if (stat.op == OP_READ) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_HERE;
               state_in   = ST_READ_WAIT;
            end else if (stat.op == OP_DELETE) begin
               state_in = ST_DEL_CHECK;
            end else if (stat.full_err) begin
               cmd.note_status = 1'b1;
               cmd.status_code = STATUS_FULL;
               state_in        = ST_FINISH;
            end else begin
               state_in = ST_INS_CHECK;
            end
         end
         ST_READ_WAIT: begin
            cmd.note_read = 1'b1;
            state_in      = ST_FINISH;
         end
         ST_INS_CHECK: begin
            if (stat.at_target) begin
               cmd.wr_en   = 1'b1;
               cmd.wr_sel  = WR_NEW;
               cmd.cnt_inc = 1'b1;
               state_in    = ST_FINISH;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_PREV;
               state_in   = ST_INS_MOVE;
            end
         end
         ST_INS_MOVE: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = WR_MOVED;
            cmd.idx_dec = 1'b1;
            state_in    = ST_INS_CHECK;
         end
         ST_DEL_CHECK: begin
            if (stat.at_last) begin
               cmd.cnt_dec = 1'b1;
               state_in    = ST_FINISH;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_NEXT;
               state_in   = ST_DEL_MOVE;
            end
         end
         ST_DEL_MOVE: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = WR_MOVED;
            cmd.idx_inc = 1'b1;
            state_in    = ST_DEL_CHECK;
         end
         ST_FINISH: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

`ifndef SYNTHESIS
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.ready |-> (state_ff == ST_IDLE))
      else $error("request taken outside idle");

   a_move_then_check: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INS_MOVE) |-> ($past(state_ff) == ST_INS_CHECK))
      else $error("entry move without a preceding read");

   a_single_count_step: assert property (@(posedge clock) disable iff (reset)
      !(cmd.cnt_inc && cmd.cnt_dec))
      else $error("count stepped both ways");
`endif

endmodule

[rtl/core/indexed_list_store_unit.sv]
// Indexed list store top level: ordered list of signed 32-bit entries.
// Depends on ils_pkg, ils_if, ils_ctrl and ils_datapath.
//
// Usage:
//   req_ch carries one transaction per request: kind (read, insert front,
//   append, insert at position, delete), position and value. rsp_ch returns
//   exactly one transaction per request: read_valid, read_value, status and
//   entry_count (count after the request, low 7 bits).
//   One request is worked on at a time; req_ch.ready is high only when the
//   controller is idle. Entries sit in a single-port-write, single-port-read
//   memory, so an insert or delete moves one entry at a time: a read, then a write.
//   An insert shifts entries up one place from the end down to the position,
//   then writes the new value there and raises the count; a delete shifts
//   entries down one place from the position to the end, then lowers the
//   count. Rejected or unknown requests move no entries.
//   The next request is taken in the cycle after the response is loaded. The
//   response sits in an output register; a new request is taken while it
//   waits, and finishing work stalls only until rsp_ch takes the old one.
//   Reset empties the store at once (count cleared); no clearing pass.
module indexed_list_store_unit
   import ils_pkg::*;
#(
   parameter int CAPACITY = 64
) (
   input  logic      clock,
   input  logic      reset,
   ils_req_if.sink   req_ch,
   ils_rsp_if.source rsp_ch
);

   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;

   ils_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   ils_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .cmd   (cmd),
      .stat  (stat)
   );

endmodule
